FILE: rtl/ghs_pkg.sv
package ghs_pkg;

	localparam int MAX_RESULTS = 8;
	localparam int RES_CW      = 4;
	localparam int RES_IW      = 3;
	localparam int NODE_W_MAX  = 16;
	localparam int W_BITS      = 17;
	localparam int LVL_BITS    = 4;
	localparam logic [W_BITS-1:0] INF_WEIGHT = 17'd100000;

	typedef enum logic [3:0] {
		C_LOAD      = 4'd0,
		C_START     = 4'd1,
		C_CONNECT   = 4'd2,
		C_INITIATE  = 4'd3,
		C_TEST      = 4'd4,
		C_ACCEPT    = 4'd5,
		C_REJECT    = 4'd6,
		C_REPORT    = 4'd7,
		C_CHROOT    = 4'd8,
		C_TERMINATE = 4'd9,
		C_IDLE      = 4'd10,
		C_QUERY     = 4'd11
	} cmd_t;

	typedef enum logic [3:0] {
		K_CONNECT   = 4'd0,
		K_INITIATE  = 4'd1,
		K_TEST      = 4'd2,
		K_ACCEPT    = 4'd3,
		K_REJECT    = 4'd4,
		K_REPORT    = 4'd5,
		K_CHROOT    = 4'd6,
		K_TERMINATE = 4'd7,
		K_NONE      = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		M_BASIC    = 2'd0,
		M_BRANCH   = 2'd1,
		M_REJECTED = 2'd2
	} mark_t;

	typedef enum logic [1:0] {
		D_CONNECT = 2'd0,
		D_REPORT  = 2'd1,
		D_TEST    = 2'd2
	} def_t;

	typedef struct packed {
		kind_t                  kind;
		logic [NODE_W_MAX-1:0]  dest;
		logic [LVL_BITS-1:0]    lvl;
		logic [W_BITS-1:0]      name;
		logic                   st;
		logic [W_BITS-1:0]      weight;
		logic [1:0]             status;
	} res_t;

	function automatic res_t mk_res(kind_t k, logic [NODE_W_MAX-1:0] d,
			logic [LVL_BITS-1:0] l, logic [W_BITS-1:0] n, logic s,
			logic [W_BITS-1:0] w, logic [1:0] m);
		res_t r;
		r.kind   = k;
		r.dest   = d;
		r.lvl    = l;
		r.name   = n;
		r.st     = s;
		r.weight = w;
		r.status = m;
		return r;
	endfunction

endpackage

FILE: rtl/ghs_defer_fifo.sv
module ghs_defer_fifo import ghs_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int DW    = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	input  logic          pop,
	output logic [DW-1:0] pop_data,
	output logic          empty,
	output logic          full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);

	logic [DW-1:0] mem [DEPTH];
	logic [PW-1:0] head_q, tail_q;
	logic [FW-1:0] fill_q;
	logic [DW-1:0] rd_q;

	assign empty    = (fill_q == '0);
	assign full     = (fill_q == FW'(DEPTH));
	assign pop_data = rd_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= push_data;
		end
		if (pop) begin
			rd_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);
			end
			if (pop) begin
				head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

endmodule

FILE: rtl/ghs_res_buf.sv
module ghs_res_buf import ghs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic clr,
	input  logic wr,
	input  res_t wr_data,
	input  logic adv,
	output res_t head,
	output logic last_entry
);

	res_t              buf_q [MAX_RESULTS];
	logic [RES_CW-1:0] count_q;
	logic [RES_IW-1:0] rd_q;

	always_comb begin
		if (count_q == '0) begin
			head       = mk_res(K_NONE, '0, '0, '0, 1'b0, '0, '0);
			last_entry = 1'b1;
		end else begin
			head       = buf_q[rd_q];
			last_entry = ({1'b0, rd_q} == count_q - RES_CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (wr && count_q < RES_CW'(MAX_RESULTS)) begin
			buf_q[count_q[RES_IW-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_q    <= '0;
		end else if (clr) begin
			count_q <= '0;
			rd_q    <= '0;
		end else begin
			if (wr && count_q < RES_CW'(MAX_RESULTS)) begin
				count_q <= count_q + RES_CW'(1);
			end
			if (adv) begin
				rd_q <= rd_q + RES_IW'(1);
			end
		end
	end

endmodule

FILE: rtl/ghs_mst_node_controller_core.sv
// One node of the GHS minimum spanning tree protocol. Each word on the request channel is an
// edge load, a start, a received protocol message, an idle slot that replays one deferred
// message, or an edge query; the node answers with one to eight result words, the final one
// flagged by last. The request channel is stalled while an item is processed and drained. An
// edge load or query passes through S_FINISH before its result word is offered in S_DRAIN; a
// message is handled by passes of the single scan and compare unit over the edge table
// (sender lookup, branch broadcast, basic edge search, child count), and its result words are
// then drained as they are taken. An idle slot first does the registered read of the deferral
// queue in S_FIFO_RD.
module ghs_mst_node_controller_core import ghs_pkg::*; #(
	parameter int MAX_NEIGHBORS = 8,
	parameter int DEFER_DEPTH   = 16,
	parameter int NODE_ID_BITS  = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [3:0]              cmd,
	input  logic [NODE_ID_BITS-1:0] sender,
	input  logic [3:0]              level,
	input  logic [16:0]             frag_name,
	input  logic                    node_state,
	input  logic [16:0]             weight,
	input  logic [2:0]              entry_sel,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [3:0]              kind,
	output logic [NODE_ID_BITS-1:0] dest,
	output logic [3:0]              out_level,
	output logic [16:0]             out_name,
	output logic                    out_state,
	output logic [16:0]             out_weight,
	output logic [1:0]              edge_status,
	output logic                    halted,
	output logic                    overflow,
	output logic                    last
);

	localparam int NB = NODE_ID_BITS;
	localparam int CW = $clog2(MAX_NEIGHBORS + 1);
	localparam int IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int DW = 2 + NB + LVL_BITS + W_BITS;
	localparam logic [NB:0] NODE_NONE = {1'b1, {NB{1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE, S_FIFO_RD, S_FIND, S_EXEC, S_SEARCH, S_BASIC,
		S_KIDS, S_RCHK, S_BCAST, S_FINISH, S_DRAIN
	} state_t;

	state_t state_q;

	logic [NB-1:0]     edge_nb [MAX_NEIGHBORS];
	logic [W_BITS-1:0] edge_wt [MAX_NEIGHBORS];
	mark_t             edge_mk [MAX_NEIGHBORS];
	logic [CW-1:0]     edge_cnt_q;

	logic [3:0]        frag_level_q;
	logic [W_BITS-1:0] frag_ident_q;
	logic              mode_found_q;
	logic [NB-1:0]     parent_q;
	logic [W_BITS-1:0] best_weight_q;
	logic [NB:0]       best_node_q;
	logic [NB:0]       test_target_q;
	logic [3:0]        report_count_q;
	logic              pend_test_q, pend_conn_q, pend_rep_q;
	logic              halt_q, ovf_q;

	cmd_t              op_cmd_q;
	logic [NB-1:0]     op_snd_q;
	logic [3:0]        op_lvl_q;
	logic [W_BITS-1:0] op_val_q;
	logic              op_st_q;
	logic [NB:0]       key_q;
	logic              cr_q;
	logic [IW-1:0]     e_q;
	logic [CW-1:0]     idx_q;
	logic [3:0]        kids_q;
	logic [NB:0]       excl_q;
	kind_t             bc_kind_q;
	logic              bc_search_q;

	logic              emit_q;
	res_t              emit_d_q;
	logic              push_q;
	logic [DW-1:0]     push_d_q;

	logic              accept, rsp_take, pop, fifo_empty, fifo_full;
	logic [DW-1:0]     pop_data;
	res_t              head;
	logic              head_last;
	cmd_t              cmd_in;
	logic [W_BITS-1:0] wsat;
	logic [IW-1:0]     qsel;
	logic              in_range;
	logic [NB-1:0]     cur_nb;
	mark_t             cur_mk;
	logic [NB-1:0]     e_nb;
	logic [W_BITS-1:0] e_wt;
	mark_t             e_mk;
	logic [3:0]        lvl_inc;
	def_t              d_what;
	logic [NB-1:0]     d_from;
	logic [3:0]        d_lvl;
	logic [W_BITS-1:0] d_val;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_DRAIN);
	assign rsp_take  = rsp_valid && !rsp_stall;
	assign cmd_in    = cmd_t'(cmd);
	assign wsat      = (weight > INF_WEIGHT) ? INF_WEIGHT : weight;
	assign qsel      = IW'(entry_sel);
	assign in_range  = (idx_q < edge_cnt_q);
	assign cur_nb    = edge_nb[idx_q[IW-1:0]];
	assign cur_mk    = edge_mk[idx_q[IW-1:0]];
	assign e_nb      = edge_nb[e_q];
	assign e_wt      = edge_wt[e_q];
	assign e_mk      = edge_mk[e_q];
	assign lvl_inc   = (frag_level_q == 4'd15) ? 4'd15 : frag_level_q + 4'd1;
	assign pop       = accept && cmd_in == C_IDLE && !halt_q && !fifo_empty;
	assign d_what    = def_t'(pop_data[DW-1 -: 2]);
	assign d_from    = pop_data[DW-3 -: NB];
	assign d_lvl     = pop_data[W_BITS +: LVL_BITS];
	assign d_val     = pop_data[W_BITS-1:0];

	assign kind        = head.kind;
	assign dest        = head.dest[NB-1:0];
	assign out_level   = head.lvl;
	assign out_name    = head.name;
	assign out_state   = head.st;
	assign out_weight  = head.weight;
	assign edge_status = head.status;
	assign halted      = halt_q;
	assign overflow    = ovf_q;
	assign last        = head_last;

	ghs_defer_fifo #(
		.DEPTH(DEFER_DEPTH),
		.DW   (DW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_q),
		.push_data(push_d_q),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (fifo_empty),
		.full     (fifo_full)
	);

	ghs_res_buf u_res (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (accept),
		.wr        (emit_q),
		.wr_data   (emit_d_q),
		.adv       (rsp_take && !head_last),
		.head      (head),
		.last_entry(head_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			edge_cnt_q     <= '0;
			frag_level_q   <= '0;
			frag_ident_q   <= '0;
			mode_found_q   <= 1'b0;
			parent_q       <= '0;
			best_weight_q  <= '0;
			best_node_q    <= '0;
			test_target_q  <= '0;
			report_count_q <= '0;
			pend_test_q    <= 1'b0;
			pend_conn_q    <= 1'b0;
			pend_rep_q     <= 1'b0;
			halt_q         <= 1'b0;
			ovf_q          <= 1'b0;
			emit_q         <= 1'b0;
			push_q         <= 1'b0;
		end else begin
			emit_q <= 1'b0;
			push_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ovf_q <= 1'b0;
						state_q <= S_FINISH;
						if (cmd_in == C_LOAD) begin
							if (edge_cnt_q < CW'(MAX_NEIGHBORS)) begin
								edge_nb[edge_cnt_q[IW-1:0]] <= sender;
								edge_wt[edge_cnt_q[IW-1:0]] <= wsat;
								edge_mk[edge_cnt_q[IW-1:0]] <= M_BASIC;
								edge_cnt_q <= edge_cnt_q + CW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end else if (cmd_in == C_QUERY) begin
							emit_q <= 1'b1;
							if ({5'd0, entry_sel} < 8'(edge_cnt_q)) begin
								emit_d_q <= mk_res(K_NONE, NODE_W_MAX'(edge_nb[qsel]), '0, '0,
									1'b0, edge_wt[qsel], edge_mk[qsel]);
							end else begin
								emit_d_q <= mk_res(K_NONE, '0, '0, '0, 1'b0, '0, '0);
							end
						end else if (halt_q || cmd_in > C_QUERY) begin
							state_q <= S_FINISH;
						end else if (cmd_in == C_START) begin
							frag_level_q   <= '0;
							mode_found_q   <= 1'b1;
							report_count_q <= '0;
							pend_conn_q    <= 1'b0;
							pend_rep_q     <= 1'b0;
							if (edge_cnt_q != '0) begin
								edge_mk[0]  <= M_BRANCH;
								pend_conn_q <= 1'b1;
								emit_q      <= 1'b1;
								emit_d_q    <= mk_res(K_CONNECT, NODE_W_MAX'(edge_nb[0]), '0, '0,
									1'b0, '0, '0);
							end
						end else if (cmd_in == C_IDLE) begin
							if (!fifo_empty) begin
								state_q <= S_FIFO_RD;
							end
						end else begin
							op_cmd_q <= cmd_in;
							op_snd_q <= sender;
							op_lvl_q <= level;
							op_val_q <= (cmd_in == C_REPORT) ? wsat : frag_name;
							op_st_q  <= node_state;
							key_q    <= {1'b0, sender};
							cr_q     <= 1'b0;
							idx_q    <= '0;
							state_q  <= S_FIND;
						end
					end
				end
				S_FIFO_RD: begin
					op_snd_q <= d_from;
					op_lvl_q <= d_lvl;
					op_val_q <= d_val;
					key_q    <= {1'b0, d_from};
					cr_q     <= 1'b0;
					idx_q    <= '0;
					unique case (d_what)
						D_CONNECT: begin
							op_cmd_q <= C_CONNECT;
							state_q  <= S_FIND;
						end
						D_REPORT: begin
							op_cmd_q <= C_REPORT;
							state_q  <= S_EXEC;
						end
						default: begin
							op_cmd_q <= C_TEST;
							state_q  <= S_FIND;
						end
					endcase
				end
				S_FIND: begin
					if (in_range) begin
						if ({1'b0, cur_nb} == key_q) begin
							e_q     <= idx_q[IW-1:0];
							state_q <= S_EXEC;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_EXEC: begin
					state_q <= S_FINISH;
					if (cr_q) begin
						if (e_mk == M_BRANCH) begin
							emit_q   <= 1'b1;
							emit_d_q <= mk_res(K_CHROOT, NODE_W_MAX'(best_node_q[NB-1:0]), '0,
								'0, 1'b0, '0, '0);
						end else begin
							edge_mk[e_q] <= M_BRANCH;
							if (!pend_conn_q) begin
								pend_conn_q <= 1'b1;
								emit_q      <= 1'b1;
								emit_d_q    <= mk_res(K_CONNECT,
									NODE_W_MAX'(best_node_q[NB-1:0]), frag_level_q, '0,
									1'b0, '0, '0);
							end
						end
					end else begin
						unique case (op_cmd_q)
							C_CONNECT: begin
								if (op_lvl_q < frag_level_q) begin
									edge_mk[e_q] <= M_BRANCH;
									emit_q   <= 1'b1;
									emit_d_q <= mk_res(K_INITIATE, NODE_W_MAX'(op_snd_q),
										frag_level_q, frag_ident_q, mode_found_q, '0, '0);
								end else if (e_mk == M_BASIC) begin
									if (fifo_full) begin
										ovf_q <= 1'b1;
									end else begin
										push_q   <= 1'b1;
										push_d_q <= {D_CONNECT, op_snd_q, op_lvl_q, {W_BITS{1'b0}}};
									end
								end else begin
									emit_q   <= 1'b1;
									emit_d_q <= mk_res(K_INITIATE, NODE_W_MAX'(op_snd_q),
										lvl_inc, e_wt, 1'b0, '0, '0);
								end
							end
							C_INITIATE: begin
								frag_level_q  <= op_lvl_q;
								frag_ident_q  <= op_val_q;
								mode_found_q  <= op_st_q;
								parent_q      <= op_snd_q;
								best_node_q   <= NODE_NONE;
								best_weight_q <= INF_WEIGHT;
								test_target_q <= NODE_NONE;
								pend_conn_q   <= 1'b0;
								pend_rep_q    <= 1'b0;
								if (!op_st_q) begin
									report_count_q <= '0;
								end
								excl_q      <= {1'b0, op_snd_q};
								bc_kind_q   <= K_INITIATE;
								bc_search_q <= !op_st_q;
								idx_q       <= '0;
								state_q     <= S_BCAST;
							end
							C_TEST: begin
								if (op_lvl_q > frag_level_q) begin
									if (fifo_full) begin
										ovf_q <= 1'b1;
									end else begin
										push_q   <= 1'b1;
										push_d_q <= {D_TEST, op_snd_q, op_lvl_q, op_val_q};
									end
								end else if (op_val_q == frag_ident_q) begin
									if (e_mk == M_BASIC) begin
										edge_mk[e_q] <= M_REJECTED;
									end
									if ({1'b0, e_nb} != test_target_q) begin
										emit_q   <= 1'b1;
										emit_d_q <= mk_res(K_REJECT, NODE_W_MAX'(op_snd_q), '0,
											'0, 1'b0, '0, '0);
									end else begin
										state_q <= S_SEARCH;
									end
								end else begin
									emit_q   <= 1'b1;
									emit_d_q <= mk_res(K_ACCEPT, NODE_W_MAX'(op_snd_q), '0, '0,
										1'b0, '0, '0);
								end
							end
							C_ACCEPT: begin
								pend_test_q   <= 1'b0;
								test_target_q <= NODE_NONE;
								if (e_wt < best_weight_q) begin
									best_weight_q <= e_wt;
									best_node_q   <= {1'b0, op_snd_q};
								end
								idx_q   <= '0;
								kids_q  <= '0;
								state_q <= S_KIDS;
							end
							C_REJECT: begin
								pend_test_q <= 1'b0;
								if (e_mk == M_BASIC) begin
									edge_mk[e_q] <= M_REJECTED;
								end
								state_q <= S_SEARCH;
							end
							C_REPORT: begin
								if (op_snd_q != parent_q) begin
									if (op_val_q < best_weight_q) begin
										best_weight_q <= op_val_q;
										best_node_q   <= {1'b0, op_snd_q};
									end
									if (report_count_q != 4'd15) begin
										report_count_q <= report_count_q + 4'd1;
									end
									idx_q   <= '0;
									kids_q  <= '0;
									state_q <= S_KIDS;
								end else if (!mode_found_q) begin
									if (fifo_full) begin
										ovf_q <= 1'b1;
									end else begin
										push_q   <= 1'b1;
										push_d_q <= {D_REPORT, op_snd_q, {LVL_BITS{1'b0}}, op_val_q};
									end
								end else if (op_val_q > best_weight_q) begin
									key_q   <= best_node_q;
									cr_q    <= 1'b1;
									idx_q   <= '0;
									state_q <= S_FIND;
								end else if (op_val_q == best_weight_q &&
										best_weight_q == INF_WEIGHT) begin
									halt_q      <= 1'b1;
									excl_q      <= NODE_NONE;
									bc_kind_q   <= K_TERMINATE;
									bc_search_q <= 1'b0;
									idx_q       <= '0;
									state_q     <= S_BCAST;
								end
							end
							C_CHROOT: begin
								key_q   <= best_node_q;
								cr_q    <= 1'b1;
								idx_q   <= '0;
								state_q <= S_FIND;
							end
							default: begin
								halt_q      <= 1'b1;
								excl_q      <= {1'b0, op_snd_q};
								bc_kind_q   <= K_TERMINATE;
								bc_search_q <= 1'b0;
								idx_q       <= '0;
								state_q     <= S_BCAST;
							end
						endcase
					end
				end
				S_SEARCH: begin
					idx_q <= '0;
					if (!pend_test_q) begin
						state_q <= S_BASIC;
					end else begin
						test_target_q <= NODE_NONE;
						kids_q        <= '0;
						state_q       <= S_KIDS;
					end
				end
				S_BASIC: begin
					if (in_range) begin
						if (cur_mk == M_BASIC) begin
							pend_test_q   <= 1'b1;
							test_target_q <= {1'b0, cur_nb};
							emit_q        <= 1'b1;
							emit_d_q      <= mk_res(K_TEST, NODE_W_MAX'(cur_nb), frag_level_q,
								frag_ident_q, 1'b0, '0, '0);
							state_q       <= S_FINISH;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end else begin
						test_target_q <= NODE_NONE;
						idx_q         <= '0;
						kids_q        <= '0;
						state_q       <= S_KIDS;
					end
				end
				S_KIDS: begin
					if (in_range) begin
						if (cur_mk == M_BRANCH && cur_nb != parent_q && kids_q != 4'd15) begin
							kids_q <= kids_q + 4'd1;
						end
						idx_q <= idx_q + CW'(1);
					end else begin
						state_q <= S_RCHK;
					end
				end
				S_RCHK: begin
					if (report_count_q == kids_q && test_target_q == NODE_NONE && !pend_rep_q) begin
						pend_rep_q   <= 1'b1;
						mode_found_q <= 1'b1;
						emit_q       <= 1'b1;
						emit_d_q     <= mk_res(K_REPORT, NODE_W_MAX'(parent_q), '0, '0, 1'b0,
							best_weight_q, '0);
					end
					state_q <= S_FINISH;
				end
				S_BCAST: begin
					if (in_range) begin
						if (cur_mk == M_BRANCH && {1'b0, cur_nb} != excl_q) begin
							emit_q <= 1'b1;
							if (bc_kind_q == K_INITIATE) begin
								emit_d_q <= mk_res(K_INITIATE, NODE_W_MAX'(cur_nb), frag_level_q,
									frag_ident_q, mode_found_q, '0, '0);
							end else begin
								emit_d_q <= mk_res(K_TERMINATE, NODE_W_MAX'(cur_nb), '0, '0,
									1'b0, '0, '0);
							end
						end
						idx_q <= idx_q + CW'(1);
					end else begin
						state_q <= bc_search_q ? S_SEARCH : S_FINISH;
					end
				end
				S_FINISH: begin
					state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (rsp_take && head_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
